// ----- sv/cvwq_pkg.sv -----
// Shared types and constants of the condition variable wait queue.
`default_nettype none

package cvwq_pkg;

  localparam int THREADS = 16;
  localparam int SLOT_W  = $clog2(THREADS);
  localparam int CNT_W   = $clog2(THREADS + 1);
  localparam int TID_W   = 4;

  localparam logic [1:0] ACT_WAIT   = 2'd0;
  localparam logic [1:0] ACT_FRONT  = 2'd1;
  localparam logic [1:0] ACT_BACK   = 2'd2;
  localparam logic [1:0] ACT_BCAST  = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [TID_W-1:0] thread_id;
  } in_t;

  typedef struct packed {
    logic             wake_valid;
    logic [TID_W-1:0] woken_thread;
    logic [1:0]       status;
    logic             last;
  } out_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_WAIT,
    OP_FULL,
    OP_EMPTY,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_BCAST
  } op_e;

  typedef struct packed {
    op_e  op;
    logic first;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic bc_last;
    logic can_load;
  } sts_t;

endpackage

`default_nettype wire

// ----- sv/cvwq_ctrl.sv -----
// Controller of the wait queue: request acceptance and the broadcast sequence.
`default_nettype none

module cvwq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    action_i,
  input  wire cvwq_pkg::sts_t sts_i,
  output logic               in_stall_o,
  output cvwq_pkg::cmd_t     cmd_o
);
  import cvwq_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_BCAST = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '{op: OP_IDLE, first: 1'b0};
    case (state_q)
      S_IDLE: begin
        in_stall_o = !sts_i.can_load;
        if (in_valid_i && sts_i.can_load) begin
          case (action_i)
            ACT_WAIT:  cmd_o.op = sts_i.full ? OP_FULL : OP_WAIT;
            ACT_FRONT: cmd_o.op = sts_i.empty ? OP_EMPTY : OP_POP_FRONT;
            ACT_BACK:  cmd_o.op = sts_i.empty ? OP_EMPTY : OP_POP_BACK;
            ACT_BCAST: begin
              if (sts_i.empty) begin
                cmd_o.op = OP_EMPTY;
              end else begin
                cmd_o.op    = OP_BCAST;
                cmd_o.first = 1'b1;
                if (!sts_i.bc_last) begin
                  state_d = S_BCAST;
                end
              end
            end
            default: cmd_o.op = OP_IDLE;
          endcase
        end
      end
      S_BCAST: begin
        // Later requests stay stalled until the last id of the broadcast is emitted.
        if (sts_i.can_load) begin
          cmd_o.op = OP_BCAST;
          if (sts_i.bc_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/cvwq_dp.sv -----
// Datapath of the wait queue: id store, head and count, output register.
`default_nettype none

module cvwq_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire cvwq_pkg::cmd_t cmd_i,
  input  wire logic [cvwq_pkg::TID_W-1:0] thread_id_i,
  input  wire logic           out_stall_i,
  output cvwq_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  output cvwq_pkg::out_t      out_res_o
);
  import cvwq_pkg::*;

  // (a + b) mod THREADS, with b at most THREADS.
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                 input logic [CNT_W-1:0]  b);
    logic [CNT_W:0] s;
    s = {{(CNT_W + 1 - SLOT_W){1'b0}}, a} + {1'b0, b};
    if (s >= (CNT_W + 1)'(THREADS)) begin
      s = s - (CNT_W + 1)'(THREADS);
    end
    return s[SLOT_W-1:0];
  endfunction

  logic [TID_W-1:0]  store_q [THREADS];
  logic [SLOT_W-1:0] front_q, front_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  logic [SLOT_W-1:0] idx_sel;
  logic [SLOT_W-1:0] rd_slot;
  logic [SLOT_W-1:0] wr_slot;
  logic [TID_W-1:0]  rd_id;
  logic              bc_last;
  logic              load;

  assign idx_sel = cmd_i.first ? '0 : idx_q;
  assign bc_last = ((CNT_W'(idx_sel) + CNT_W'(1)) == count_q);
  assign wr_slot = slot_add(front_q, count_q);

  always_comb begin
    case (cmd_i.op)
      OP_POP_BACK: rd_slot = slot_add(front_q, count_q - CNT_W'(1));
      OP_BCAST:    rd_slot = slot_add(front_q, CNT_W'(idx_sel));
      default:     rd_slot = front_q;
    endcase
  end

  assign rd_id = store_q[rd_slot];
  assign load  = (cmd_i.op != OP_IDLE);

  assign sts_o.empty    = (count_q == '0);
  assign sts_o.full     = (count_q == CNT_W'(THREADS));
  assign sts_o.bc_last  = bc_last;
  assign sts_o.can_load = !out_valid_q || !out_stall_i;

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    idx_d   = idx_q;
    out_d   = '{wake_valid: 1'b0, woken_thread: '0, status: STAT_OK, last: 1'b1};
    case (cmd_i.op)
      OP_WAIT: begin
        count_d = count_q + CNT_W'(1);
      end
      OP_FULL:  out_d.status = STAT_FULL;
      OP_EMPTY: out_d.status = STAT_EMPTY;
      OP_POP_FRONT: begin
        out_d.wake_valid   = 1'b1;
        out_d.woken_thread = rd_id;
        front_d            = slot_add(front_q, CNT_W'(1));
        count_d            = count_q - CNT_W'(1);
      end
      OP_POP_BACK: begin
        out_d.wake_valid   = 1'b1;
        out_d.woken_thread = rd_id;
        count_d            = count_q - CNT_W'(1);
      end
      OP_BCAST: begin
        out_d.wake_valid   = 1'b1;
        out_d.woken_thread = rd_id;
        out_d.last         = bc_last;
        idx_d              = idx_sel + SLOT_W'(1);
        if (bc_last) begin
          count_d = '0;
        end
      end
      default: out_d = out_q;
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WAIT) begin
      store_q[wr_slot] <= thread_id_i;
    end
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

`default_nettype wire

// ----- sv/condvar_wait_queue.sv -----
// Top level of the condition variable wait queue.
`default_nettype none

// Wait queue of one condition variable: a double-ended queue of up to THREADS
// waiting thread ids. A wait appends at the tail, a front signal wakes the
// head, a back signal wakes the tail, and a broadcast wakes every waiter from
// head to tail, one result per id with last set on the final one. Waits, front
// and back signals, and requests that report empty or full each give one
// result. A broadcast is taken with its first id and then keeps the input
// stalled until its last id is emitted, since the store is read at one slot
// per cycle while the output register can load. Each result is registered and
// appears the cycle after its request is taken; a new request is taken while
// the output register is empty or is being emptied in the same cycle.
module condvar_wait_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire cvwq_pkg::in_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output cvwq_pkg::out_t     out_res_o
);
  import cvwq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cvwq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (in_req_i.action),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  cvwq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .thread_id_i (in_req_i.thread_id),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o)
  );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the condition variable wait queue.
`timescale 1ns / 1ps

module tb;
  import cvwq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 14;
  localparam int RAND_ITEMS  = 150;

  typedef struct {
    in_t req;
    bit  drain;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_res;

  condvar_wait_queue dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (out_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the wait queue.
  logic [TID_W-1:0] waiters [THREADS];
  int head_slot = 0;
  int waiter_cnt = 0;

  stim_t pending_q[$];
  out_t  wake_q[$];

  int plan_cnt = 0;
  int n_presented = 0;
  int n_checked = 0;
  int n_fault = 0;
  int n_waits = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_bcast = 0;
  int longest_bcast = 0;
  int cycle_cnt = 0;
  bit req_fire = 1'b0;
  bit stim_done = 1'b0;

  // No idling on either side for a stretch in the middle of the run.
  wire calm = (n_presented >= 70) && (n_presented < 110);

  function automatic void predict_wakeups(input in_t req);
    out_t r;
    int   k;
    r = '0;
    r.last = 1'b1;
    if (req.action == ACT_WAIT) begin
      n_waits++;
      if (waiter_cnt == THREADS) begin
        r.status = STAT_FULL;
        n_full++;
      end else begin
        waiters[(head_slot + waiter_cnt) % THREADS] = req.thread_id;
        waiter_cnt++;
      end
      wake_q.push_back(r);
    end else if (waiter_cnt == 0) begin
      r.status = STAT_EMPTY;
      n_empty++;
      wake_q.push_back(r);
    end else if (req.action == ACT_FRONT) begin
      r.wake_valid = 1'b1;
      r.woken_thread = waiters[head_slot];
      head_slot = (head_slot + 1) % THREADS;
      waiter_cnt--;
      wake_q.push_back(r);
    end else if (req.action == ACT_BACK) begin
      r.wake_valid = 1'b1;
      r.woken_thread = waiters[(head_slot + waiter_cnt - 1) % THREADS];
      waiter_cnt--;
      wake_q.push_back(r);
    end else begin
      // Broadcast drains the queue but leaves the head slot where it was.
      n_bcast++;
      if (waiter_cnt > longest_bcast) longest_bcast = waiter_cnt;
      for (k = 0; k < waiter_cnt; k++) begin
        r.wake_valid = 1'b1;
        r.woken_thread = waiters[(head_slot + k) % THREADS];
        r.last = (k == waiter_cnt - 1);
        wake_q.push_back(r);
      end
      waiter_cnt = 0;
    end
  endfunction

  function automatic string fmt_res(input out_t r);
    return $sformatf("valid=%0b id=%0d status=%0d last=%0b",
                     r.wake_valid, r.woken_thread, r.status, r.last);
  endfunction

  task automatic queue_request(input logic [1:0] act, input int tid,
                               input bit drain);
    stim_t s;
    s.req.action = act;
    s.req.thread_id = TID_W'(tid);
    s.drain = drain;
    pending_q.push_back(s);
    case (act)
      ACT_WAIT:  if (plan_cnt < THREADS) plan_cnt++;
      ACT_BCAST: plan_cnt = 0;
      default:   if (plan_cnt > 0) plan_cnt--;
    endcase
  endtask

  task automatic report_fault(input string msg);
    n_fault++;
    if (n_fault <= 10) $display("[%0d] %s", cycle_cnt, msg);
  endtask

  always @(posedge clk) begin
    req_fire <= rst_n && in_valid && !in_stall;
  end

  // Request driver. Each request is predicted as it is first put on the bus:
  // it stays there unchanged until taken, so the order matches acceptance.
  always @(negedge clk) begin
    bit    go;
    stim_t s;
    if (rst_n && (!in_valid || req_fire)) begin
      go = (pending_q.size() != 0)
           && !(pending_q[0].drain && wake_q.size() != 0)
           && (calm || $urandom_range(99) >= IDLE_PCT);
      if (go) begin
        s = pending_q.pop_front();
        predict_wakeups(s.req);
        in_req <= s.req;
        n_presented <= n_presented + 1;
      end
      in_valid <= go;
      if (!go && pending_q.size() == 0) stim_done <= 1'b1;
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (wake_q.size() == 0) begin
        report_fault($sformatf("unexpected result %s", fmt_res(out_res)));
      end else begin
        want = wake_q.pop_front();
        n_checked++;
        if (out_res.wake_valid !== want.wake_valid
            || out_res.woken_thread !== want.woken_thread
            || out_res.status !== want.status
            || out_res.last !== want.last) begin
          report_fault($sformatf("result %0d: expected %s, got %s",
                                 n_checked, fmt_res(want), fmt_res(out_res)));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_cnt, wake_q.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int         n_rand;
    int         pick;
    bit         drain;
    bit         first_seg;
    logic [1:0] act;

    // Empty-queue cases, duplicate ids, both ends, a short broadcast.
    queue_request(ACT_BCAST, 0, 1'b0);
    queue_request(ACT_FRONT, 15, 1'b0);
    queue_request(ACT_BACK, 0, 1'b0);
    queue_request(ACT_WAIT, 0, 1'b0);
    queue_request(ACT_WAIT, 15, 1'b0);
    queue_request(ACT_WAIT, 15, 1'b0);
    queue_request(ACT_WAIT, 10, 1'b0);
    queue_request(ACT_FRONT, 3, 1'b0);
    queue_request(ACT_BACK, 12, 1'b0);
    queue_request(ACT_WAIT, 5, 1'b0);
    queue_request(ACT_BCAST, 7, 1'b0);
    queue_request(ACT_BACK, 0, 1'b0);
    queue_request(ACT_WAIT, 9, 1'b0);
    queue_request(ACT_FRONT, 0, 1'b0);
    queue_request(ACT_BCAST, 15, 1'b0);

    // Random part: fills that overflow and end in a long broadcast or a back signal,
    // mixed with segments of arbitrary requests.
    n_rand = 0;
    first_seg = 1'b1;
    while (n_rand < RAND_ITEMS) begin
      drain = first_seg || ($urandom_range(3) == 0);
      if (first_seg || $urandom_range(3) == 0) begin
        while (plan_cnt < THREADS) begin
          if ($urandom_range(9) == 0)
            queue_request($urandom_range(1) ? ACT_FRONT : ACT_BACK, $urandom_range(15), drain);
          else
            queue_request(ACT_WAIT, $urandom_range(15), drain);
          drain = 1'b0;
          n_rand++;
        end
        repeat ($urandom_range(1, 3)) begin
          queue_request(ACT_WAIT, $urandom_range(15), 1'b0);
          n_rand++;
        end
        if (first_seg || $urandom_range(1))
          queue_request(ACT_BCAST, $urandom_range(15), 1'b0);
        else
          queue_request(ACT_BACK, $urandom_range(15), 1'b0);
        n_rand++;
      end else begin
        repeat ($urandom_range(8, 20)) begin
          pick = $urandom_range(99);
          act = (pick < 45) ? ACT_WAIT : (pick < 65) ? ACT_FRONT :
                (pick < 85) ? ACT_BACK : ACT_BCAST;
          queue_request(act, $urandom_range(15), drain);
          drain = 1'b0;
          n_rand++;
        end
      end
      first_seg = 1'b0;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (stim_done);
    while (wake_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d requests: %0d waits (%0d dropped as full), %0d hit an empty queue,",
             n_presented, n_waits, n_full, n_empty);
    $display("%0d broadcasts (longest %0d waiters), %0d results checked, %0d faults.",
             n_bcast, longest_bcast, n_checked, n_fault);
    if (n_fault == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
sv/cvwq_pkg.sv
sv/cvwq_ctrl.sv
sv/cvwq_dp.sv
sv/condvar_wait_queue.sv
tb/tb.sv
